// ===== rtl/strmq_pkg.sv =====
`timescale 1ns / 1ps

package strmq_pkg;

  // Field widths of the words on both channels, and the width of a level index
  localparam int VALUE_W = 32;
  localparam int IDX_W   = 11;
  localparam int LG_W    = 4;

  // Default sizing of the table
  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int LEVELS_DEF       = 10;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic signed [VALUE_W-1:0]  element_value;
    logic                       is_last_element;
    logic [IDX_W-1:0]           left_index;
    logic [IDX_W-1:0]           right_index;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  max_value;
    logic [IDX_W-1:0]           max_position;
    logic                       query_ok;
  } out_word_t;

  // Table port controls
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } tbl_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QRY,
    ST_BLD_CHK,
    ST_BLD_WR
  } strmq_state_t;

  // Index of the highest set bit; zero for an input of zero
  function automatic logic [LG_W-1:0] floor_log2(input logic [IDX_W-1:0] x);
    logic [LG_W-1:0] r;
    r = '0;
    for (int i = 0; i < IDX_W; i++) begin
      if (x[i]) begin
        r = LG_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/strmq_table.sv =====
`timescale 1ns / 1ps

module strmq_table #(
  parameter int POS_W = 11,
  parameter int DEPTH = 11264
) (
  input  logic                            clk,
  input  strmq_pkg::tbl_ctl_t             ctl,
  input  logic [$clog2(DEPTH)-1:0]        wr_addr,
  input  logic [strmq_pkg::VALUE_W+POS_W-1:0] wr_data,
  input  logic [$clog2(DEPTH)-1:0]        rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0]        rd_addr_b,
  output logic [strmq_pkg::VALUE_W+POS_W-1:0] best
);

  localparam int ENT_W = strmq_pkg::VALUE_W + POS_W;

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_a_r;
  logic [ENT_W-1:0] rd_b_r;

  logic signed [strmq_pkg::VALUE_W-1:0] val_a;
  logic signed [strmq_pkg::VALUE_W-1:0] val_b;
  logic [POS_W-1:0]                     pos_a;
  logic [POS_W-1:0]                     pos_b;
  logic                                 b_wins;

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  // Pick the larger pair: value first, then the later position
  always_comb begin
    val_a  = rd_a_r[ENT_W-1 -: strmq_pkg::VALUE_W];
    val_b  = rd_b_r[ENT_W-1 -: strmq_pkg::VALUE_W];
    pos_a  = rd_a_r[POS_W-1:0];
    pos_b  = rd_b_r[POS_W-1:0];
    b_wins = (val_b > val_a) || ((val_b == val_a) && (pos_b > pos_a));
    best   = b_wins ? rd_b_r : rd_a_r;
  end

endmodule

// ===== rtl/sparse_table_range_max.sv =====
`timescale 1ns / 1ps
// Load: a word is taken whenever idle. Query: the table's registered read, then the output
//   register, waiting in ST_QRY while an earlier answer stalls; no word is taken meanwhile.
// Build after the last load: per level j, max(n - 2^j + 1, 0) entries, each one read step
//   and one write step through the table, a check step per level, then a closing step.
// Reset clears count, built flag, sequencer and output valid; the table memory is
//   not cleared, only entries written by the current load and build feed an answer.
module sparse_table_range_max #(
  parameter int MAX_ELEMENTS = strmq_pkg::MAX_ELEMENTS_DEF,
  parameter int LEVELS       = strmq_pkg::LEVELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  strmq_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output strmq_pkg::out_word_t out_data
);

  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int POS_W  = CNT_W;
  localparam int DEPTH  = MAX_ELEMENTS * (LEVELS + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LVL_W  = $clog2(LEVELS + 2);
  localparam int CW     = (CNT_W > strmq_pkg::IDX_W) ? CNT_W : strmq_pkg::IDX_W;
  localparam int SW     = ((CNT_W > LEVELS + 1) ? CNT_W : LEVELS + 1) + 1;
  localparam int ENT_W  = strmq_pkg::VALUE_W + POS_W;
  localparam int IW     = strmq_pkg::IDX_W;

  strmq_pkg::strmq_state_t state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    built_r, built_nxt;
  logic [LVL_W-1:0]        lvl_r, lvl_nxt;
  logic [CNT_W-1:0]        k_r, k_nxt;
  logic [SW-1:0]           half_r, half_nxt;
  logic [ADDR_W-1:0]       base_prev_r, base_prev_nxt;
  logic [ADDR_W-1:0]       base_cur_r, base_cur_nxt;
  logic                    q_ok_r, q_ok_nxt;
  logic                    out_valid_r, out_valid_nxt;
  strmq_pkg::out_word_t    out_data_r, out_data_nxt;

  strmq_pkg::tbl_ctl_t     ctl;
  logic [ADDR_W-1:0]       wr_addr;
  logic [ENT_W-1:0]        wr_data;
  logic [ADDR_W-1:0]       rd_addr_a;
  logic [ADDR_W-1:0]       rd_addr_b;
  logic [ENT_W-1:0]        best;

  // Query decode
  logic                    q_valid;
  logic [IW-1:0]           q_len;
  logic [strmq_pkg::LG_W-1:0] lg_raw;
  logic [LVL_W-1:0]        lg;
  logic [ADDR_W-1:0]       q_base;
  logic [IW-1:0]           q_left0;
  logic [IW-1:0]           q_right0;

  // Load and build helpers
  logic [CNT_W-1:0]        eff_count;
  logic [SW-1:0]           k_half;
  logic                    bld_fits;

  strmq_table #(
    .POS_W (POS_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk       (clk),
    .ctl       (ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .best      (best)
  );

  assign in_stall  = (state_r != strmq_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Work out range check, level and both window addresses of a query
  always_comb begin
    q_valid = built_r && (count_r != '0) && (in_data.left_index != '0) &&
              (in_data.left_index <= in_data.right_index) &&
              (CW'(in_data.right_index) <= CW'(count_r));
    q_len   = in_data.right_index - in_data.left_index + IW'(1);
    lg_raw  = strmq_pkg::floor_log2(q_len);
    if (int'(lg_raw) > LEVELS) begin
      lg = LVL_W'(LEVELS);
    end else begin
      lg = LVL_W'(lg_raw);
    end
    q_base   = ADDR_W'(lg) * ADDR_W'(MAX_ELEMENTS);
    q_left0  = in_data.left_index - IW'(1);
    q_right0 = in_data.right_index - (IW'(1) << lg);
  end

  always_comb begin
    eff_count = built_r ? '0 : count_r;
    k_half    = SW'(k_r) + half_r;
    bld_fits  = (SW'(k_r) + (half_r << 1)) <= SW'(count_r);
  end

  // Sequencer: decode words, walk the build, hand out results
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    built_nxt     = built_r;
    lvl_nxt       = lvl_r;
    k_nxt         = k_r;
    half_nxt      = half_r;
    base_prev_nxt = base_prev_r;
    base_cur_nxt  = base_cur_r;
    q_ok_nxt      = q_ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    wr_addr       = ADDR_W'(eff_count);
    wr_data       = {in_data.element_value, POS_W'(eff_count + CNT_W'(1))};
    rd_addr_a     = q_base + ADDR_W'(q_left0);
    rd_addr_b     = q_base + ADDR_W'(q_right0);

    unique case (state_r)
      strmq_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == strmq_pkg::REQ_LOAD) begin
            // Store at level 0, drop beyond capacity
            built_nxt = 1'b0;
            count_nxt = eff_count;
            if (eff_count < CNT_W'(MAX_ELEMENTS)) begin
              ctl.wr_en = 1'b1;
              count_nxt = eff_count + CNT_W'(1);
            end
            if (in_data.is_last_element) begin
              state_nxt     = strmq_pkg::ST_BLD_CHK;
              lvl_nxt       = LVL_W'(1);
              k_nxt         = '0;
              half_nxt      = SW'(1);
              base_prev_nxt = '0;
              base_cur_nxt  = ADDR_W'(MAX_ELEMENTS);
            end
          end else begin
            ctl.rd_en = 1'b1;
            q_ok_nxt  = q_valid;
            state_nxt = strmq_pkg::ST_QRY;
          end
        end
      end

      strmq_pkg::ST_QRY: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = strmq_pkg::ST_IDLE;
          if (q_ok_r) begin
            out_data_nxt.max_value    = best[ENT_W-1 -: strmq_pkg::VALUE_W];
            out_data_nxt.max_position = IW'(best[POS_W-1:0]);
            out_data_nxt.query_ok     = 1'b1;
          end else begin
            out_data_nxt = '0;
          end
        end
      end

      strmq_pkg::ST_BLD_CHK: begin
        rd_addr_a = base_prev_r + ADDR_W'(k_r);
        rd_addr_b = base_prev_r + ADDR_W'(k_half);
        if (lvl_r == LVL_W'(LEVELS + 1)) begin
          built_nxt = 1'b1;
          state_nxt = strmq_pkg::ST_IDLE;
        end else if (bld_fits) begin
          ctl.rd_en = 1'b1;
          state_nxt = strmq_pkg::ST_BLD_WR;
        end else begin
          // Advance to the next level
          lvl_nxt       = lvl_r + LVL_W'(1);
          k_nxt         = '0;
          half_nxt      = half_r << 1;
          base_prev_nxt = base_cur_r;
          base_cur_nxt  = base_cur_r + ADDR_W'(MAX_ELEMENTS);
        end
      end

      strmq_pkg::ST_BLD_WR: begin
        ctl.wr_en = 1'b1;
        wr_addr   = base_cur_r + ADDR_W'(k_r);
        wr_data   = best;
        k_nxt     = k_r + CNT_W'(1);
        state_nxt = strmq_pkg::ST_BLD_CHK;
      end

      default: begin
        state_nxt = strmq_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= strmq_pkg::ST_IDLE;
      count_r     <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Build walk and payload
  always_ff @(posedge clk) begin
    lvl_r       <= lvl_nxt;
    k_r         <= k_nxt;
    half_r      <= half_nxt;
    base_prev_r <= base_prev_nxt;
    base_cur_r  <= base_cur_nxt;
    q_ok_r      <= q_ok_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

// ===== bench/sparse_table_range_max_tb.sv =====
`timescale 1ns / 1ps

module sparse_table_range_max_tb;

  localparam int VALUE_W    = strmq_pkg::VALUE_W;
  localparam int IDX_W      = strmq_pkg::IDX_W;
  localparam int CAPACITY   = strmq_pkg::MAX_ELEMENTS_DEF;
  localparam int TOP_LEVEL  = strmq_pkg::LEVELS_DEF;
  localparam int PLAN_ROWS  = 23;
  localparam int WORD_GOAL  = PLAN_ROWS + 1700;
  localparam int MAX_REPORT = 10;

  localparam strmq_pkg::out_word_t REFUSED = '{default: '0};

  // (value, position) pair as held in each window of the table
  typedef struct packed {
    logic signed [VALUE_W-1:0] v;
    logic [IDX_W-1:0]          p;
  } peak_t;

  typedef struct {
    strmq_pkg::in_word_t  w;
    bit                   fixed;
    strmq_pkg::out_word_t want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  strmq_pkg::in_word_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  strmq_pkg::out_word_t out_data;

  // Local copy of the block's state
  peak_t       window_peaks [0:TOP_LEVEL][0:CAPACITY-1];
  int unsigned loaded_count = 0;
  bit          table_ready = 1'b0;

  strmq_pkg::out_word_t pending_answers [$];
  int          fail_count = 0;
  int          words_sent = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  int          quiet_left = 0;

  sparse_table_range_max uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pair order: value first, larger position on equal values
  function automatic bit outranks(peak_t a, peak_t b);
    if (a.v != b.v) begin
      return $signed(a.v) > $signed(b.v);
    end
    return a.p > b.p;
  endfunction

  // Advance the local state by one word and work out its answer, if any
  function automatic void track_word(input strmq_pkg::in_word_t w, output bit answers,
                                     output strmq_pkg::out_word_t ans);
    int unsigned width;
    int unsigned half;
    int unsigned span;
    int unsigned lg;
    peak_t       a;
    peak_t       b;
    answers = 1'b0;
    ans = REFUSED;
    if (w.req_type == strmq_pkg::REQ_LOAD) begin
      if (table_ready) begin
        loaded_count = 0;
        table_ready = 1'b0;
      end
      if (loaded_count < CAPACITY) begin
        window_peaks[0][loaded_count] = '{w.element_value, IDX_W'(loaded_count + 1)};
        loaded_count++;
      end
      if (w.is_last_element) begin
        for (int j = 1; j <= TOP_LEVEL; j++) begin
          width = 1 << j;
          half = width >> 1;
          for (int i = 1; i + width - 1 <= loaded_count; i++) begin
            a = window_peaks[j-1][i-1];
            b = window_peaks[j-1][i+half-1];
            window_peaks[j][i-1] = outranks(b, a) ? b : a;
          end
        end
        table_ready = 1'b1;
      end
    end else begin
      answers = 1'b1;
      if (table_ready && loaded_count > 0 && w.left_index >= 1 &&
          w.left_index <= w.right_index && w.right_index <= loaded_count) begin
        span = w.right_index - w.left_index + 1;
        lg = 0;
        for (int unsigned s = span; s > 1; s >>= 1) lg++;
        if (lg > TOP_LEVEL) lg = TOP_LEVEL;
        a = window_peaks[lg][w.left_index-1];
        b = window_peaks[lg][w.right_index-(1 << lg)];
        if (outranks(b, a)) a = b;
        ans.max_value = a.v;
        ans.max_position = a.p;
        ans.query_ok = 1'b1;
      end
    end
  endfunction

  // Load word; the range fields carry junk
  function automatic strmq_pkg::in_word_t ld(logic signed [VALUE_W-1:0] v, logic last);
    strmq_pkg::in_word_t w;
    w.req_type = strmq_pkg::REQ_LOAD;
    w.element_value = v;
    w.is_last_element = last;
    w.left_index = IDX_W'($urandom);
    w.right_index = IDX_W'($urandom);
    return w;
  endfunction

  // Query word; value and last flag carry junk
  function automatic strmq_pkg::in_word_t qr(int unsigned l, int unsigned r);
    strmq_pkg::in_word_t w;
    w.req_type = strmq_pkg::REQ_QUERY;
    w.element_value = $urandom;
    w.is_last_element = 1'($urandom_range(0, 1));
    w.left_index = IDX_W'(l);
    w.right_index = IDX_W'(r);
    return w;
  endfunction

  // Offer one word in bursts with random gaps, then record its answer
  task automatic send(input strmq_pkg::in_word_t w, input bit fixed = 1'b0,
                      input strmq_pkg::out_word_t want = REFUSED);
    int                   gap;
    bit                   answers;
    strmq_pkg::out_word_t ans;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    track_word(w, answers, ans);
    if (answers) pending_answers.push_back(fixed ? want : ans);
  endtask

  // Receiver stall pattern: runs of stall between quiet stretches
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (quiet_left != 0) begin
        quiet_left <= quiet_left - 1;
      end else begin
        stall_left <= $urandom_range(0, 5);
        quiet_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 4);
      end
    end
  end

  // Check each accepted result against the oldest pending answer
  always @(posedge clk) begin : check_results
    strmq_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORT)
          $display("unexpected result: value %0d pos %0d ok %0b",
                   $signed(out_data.max_value), out_data.max_position, out_data.query_ok);
      end else begin
        want = pending_answers.pop_front();
        if (out_data.max_value !== want.max_value ||
            out_data.max_position !== want.max_position ||
            out_data.query_ok !== want.query_ok) begin
          fail_count++;
          if (fail_count <= MAX_REPORT)
            $display("mismatch: expected value %0d pos %0d ok %0b, got value %0d pos %0d ok %0b",
                     $signed(want.max_value), want.max_position, want.query_ok,
                     $signed(out_data.max_value), out_data.max_position, out_data.query_ok);
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t   plan [PLAN_ROWS];
    int          size_n;
    int          style;
    int          v;
    int          nq;
    int          extra;
    int unsigned n;
    int unsigned l;
    int unsigned r;
    bit          big;
    bit          big_done;
    bit          broken;
    bit          last;

    big_done = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: extremes, ties, refused ranges, reload after build
    plan = '{
      '{qr(1, 1), 1'b1, REFUSED},
      '{ld(32'sh8000_0000, 1'b0), 1'b0, REFUSED},
      '{ld(32'sh7fff_ffff, 1'b0), 1'b0, REFUSED},
      '{ld(32'sd5, 1'b0), 1'b0, REFUSED},
      '{ld(32'sh7fff_ffff, 1'b0), 1'b0, REFUSED},
      '{ld(-32'sd1, 1'b1), 1'b0, REFUSED},
      '{qr(1, 5), 1'b1, strmq_pkg::out_word_t'{32'sh7fff_ffff, 11'd4, 1'b1}},
      '{qr(1, 1), 1'b1, strmq_pkg::out_word_t'{32'sh8000_0000, 11'd1, 1'b1}},
      '{qr(2, 3), 1'b0, REFUSED},
      '{qr(3, 5), 1'b0, REFUSED},
      '{qr(0, 3), 1'b1, REFUSED},
      '{qr(4, 3), 1'b1, REFUSED},
      '{qr(1, 6), 1'b1, REFUSED},
      '{qr(2047, 2047), 1'b1, REFUSED},
      '{qr(5, 5), 1'b0, REFUSED},
      '{ld(32'sd7, 1'b0), 1'b0, REFUSED},
      '{qr(1, 1), 1'b1, REFUSED},
      '{ld(32'sd7, 1'b1), 1'b0, REFUSED},
      '{qr(1, 2), 1'b1, strmq_pkg::out_word_t'{32'sd7, 11'd2, 1'b1}},
      '{ld(-32'sd3, 1'b1), 1'b0, REFUSED},
      '{qr(1, 1), 1'b0, REFUSED},
      '{qr(1, 2), 1'b1, REFUSED},
      '{qr(2, 1), 1'b1, REFUSED}
    };
    foreach (plan[i]) send(plan[i].w, plan[i].fixed, plan[i].want);

    // Random arrays: load, build, then a run of queries
    while (words_sent < WORD_GOAL) begin
      big = !big_done && words_sent > 500;
      case ($urandom_range(0, 9))
        0:       size_n = $urandom_range(101, 300);
        1, 2, 3: size_n = $urandom_range(17, 100);
        default: size_n = $urandom_range(1, 16);
      endcase
      if (big) size_n = CAPACITY;
      style = $urandom_range(0, 3);
      broken = !big && $urandom_range(0, 9) == 0;

      for (int k = 1; k <= size_n; k++) begin
        case (style)
          0:       v = $urandom;
          1:       v = int'($urandom_range(0, 6)) - 3;
          2: begin
            case ($urandom_range(0, 4))
              0:       v = 32'sh8000_0000;
              1:       v = 32'sh7fff_ffff;
              2:       v = 0;
              3:       v = -1;
              default: v = $urandom;
            endcase
          end
          default: v = -int'($urandom_range(0, 1000));
        endcase
        // a broken array takes queries mid-load and may leave the last flag off
        if (broken && $urandom_range(0, 3) == 0)
          send(qr($urandom_range(0, 40), $urandom_range(0, 40)));
        last = (k == size_n) && !big && !(broken && $urandom_range(0, 1) == 1);
        send(ld(v, last));
      end

      // Full table: drop loads past capacity, the last of them ends the array
      if (big) begin
        big_done = 1'b1;
        extra = $urandom_range(1, 3);
        for (int k = 1; k <= extra; k++) send(ld($urandom, k == extra));
        send(qr(1, CAPACITY));
        send(qr(CAPACITY, CAPACITY));
        send(qr(1, CAPACITY + 1));
      end

      nq = $urandom_range(2, 30);
      for (int q = 0; q < nq; q++) begin
        n = loaded_count;
        if ($urandom_range(0, 9) < 8 && table_ready && n > 0) begin
          l = $urandom_range(1, n);
          if ($urandom_range(0, 1) == 0) r = $urandom_range(l, n);
          else r = (l + $urandom_range(0, 7) > n) ? n : l + $urandom_range(0, 7);
        end else begin
          case ($urandom_range(0, 3))
            0: begin
              l = 0;
              r = $urandom_range(0, 2047);
            end
            1: begin
              l = $urandom_range(2, 2047);
              r = $urandom_range(1, l - 1);
            end
            2: begin
              l = $urandom_range(1, n + 1);
              r = $urandom_range(n + 1, 2047);
            end
            default: begin
              l = $urandom_range(0, 2047);
              r = $urandom_range(0, 2047);
            end
          endcase
        end
        send(qr(l, r));
      end
    end

    // Drain, then allow a settling margin
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("sparse_table_range_max verification clean");
    end else begin
      $display("sparse_table_range_max verification failed");
    end
    $finish;
  end

  // Hard stop
  initial begin
    #6_000_000;
    $display("sparse_table_range_max verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/strmq_pkg.sv
rtl/strmq_table.sv
rtl/sparse_table_range_max.sv
bench/sparse_table_range_max_tb.sv
